/* sv/cluhn_pkg.sv */
// ----------------------------------------------------------------------------
// cluhn_pkg
// shared codes, types and digit helpers for the card number classifier
// ----------------------------------------------------------------------------
`default_nettype none

package cluhn_pkg;

    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 2;
    localparam int COUNT_W = 5;
    localparam int DIGIT_W = 4;

    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [DIGIT_W-1:0] digit_t;

    localparam class_t CLASS_INVALID = 2'd0;
    localparam class_t CLASS_VISA    = 2'd1;
    localparam class_t CLASS_MASTER  = 2'd2;
    localparam class_t CLASS_AMEX    = 2'd3;

    localparam char_t  CHAR_ZERO  = 8'd48;
    localparam char_t  CHAR_NINE  = 8'd57;
    localparam count_t COUNT_SHOW = 5'd31;

    // luhn doubling of one decimal digit
    function automatic digit_t luhn_double(input digit_t d);
        logic [DIGIT_W:0] v;
        begin
            v = {d, 1'b0};
            if (v > 5'd9)
            begin
                v = v - 5'd9;
            end
            luhn_double = v[DIGIT_W-1:0];
        end
    endfunction

    // sum of two values below ten, mod ten
    function automatic digit_t add_mod10(input digit_t a, input digit_t b);
        logic [DIGIT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            if (s >= 5'd10)
            begin
                s = s - 5'd10;
            end
            add_mod10 = s[DIGIT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/cluhn_char_if.sv */
// ----------------------------------------------------------------------------
// cluhn_char_if
// character channel: one ascii character per item with a last flag
// ----------------------------------------------------------------------------
`default_nettype none

interface cluhn_char_if;

    logic                valid;
    logic                ready;
    cluhn_pkg::char_t    char_code;
    logic                is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);

endinterface

`default_nettype wire

/* sv/cluhn_result_if.sv */
// ----------------------------------------------------------------------------
// cluhn_result_if
// result channel: card class and character count of one number
// ----------------------------------------------------------------------------
`default_nettype none

interface cluhn_result_if;

    logic                valid;
    logic                ready;
    cluhn_pkg::class_t   card_class;
    cluhn_pkg::count_t   digit_count;

    modport source (output valid, output card_class, output digit_count, input ready);
    modport sink   (input valid, input card_class, input digit_count, output ready);

endinterface

`default_nettype wire

/* sv/card_number_luhn_classifier.sv */
// ----------------------------------------------------------------------------
// card_number_luhn_classifier
// luhn mod 10 check and issuer prefix classing of a streamed card number
// ----------------------------------------------------------------------------
//  channel  | dir | payload                  | note
//  chars    | in  | char_code[7:0], is_last  | leftmost character first
//  result   | out | card_class[1:0],         | one item per number, on is_last
//           |     | digit_count[4:0]         |
//
//  one character per cycle unless a stalled result holds a last character in the input stage
//  the path is input register, combinational mod-10 add and classing, result register
//  reset clears both valid flags and the number state
//  a stalled result only holds back a last character; others keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier #(
    parameter int COUNT_LIMIT = 31
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    cluhn_char_if.sink        chars,
    cluhn_result_if.source    result
);

    localparam int CW = $clog2(COUNT_LIMIT + 1);

    typedef logic [CW-1:0] len_t;

    localparam len_t LIMIT  = len_t'(COUNT_LIMIT);
    localparam len_t LEN_13 = len_t'(13);
    localparam len_t LEN_15 = len_t'(15);
    localparam len_t LEN_16 = len_t'(16);
    localparam len_t LEN_31 = len_t'(31);

    // input stage
    logic                in_valid_reg;
    cluhn_pkg::char_t    char_reg;
    logic                last_reg;

    // number state
    len_t                count_reg,  count_next;
    cluhn_pkg::digit_t   first_reg,  first_next;
    cluhn_pkg::digit_t   second_reg, second_next;
    cluhn_pkg::digit_t   even_reg,   even_next;
    cluhn_pkg::digit_t   odd_reg,    odd_next;
    logic                bad_reg,    bad_next;

    // result stage
    logic                out_valid_reg;
    cluhn_pkg::class_t   class_reg,  class_next;
    cluhn_pkg::count_t   shown_reg,  shown_next;

    logic                advance;
    logic                is_digit;
    cluhn_pkg::digit_t   d;
    cluhn_pkg::digit_t   dd;
    cluhn_pkg::digit_t   luhn;

    assign advance = in_valid_reg && (!last_reg || !out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            char_reg <= chars.char_code;
            last_reg <= chars.is_last;
        end
    end

    always_comb
    begin
        is_digit = (char_reg >= cluhn_pkg::CHAR_ZERO) && (char_reg <= cluhn_pkg::CHAR_NINE);
        d        = cluhn_pkg::digit_t'(char_reg - cluhn_pkg::CHAR_ZERO);
        dd       = cluhn_pkg::luhn_double(d);

        first_next  = first_reg;
        second_next = second_reg;
        even_next   = even_reg;
        odd_next    = odd_reg;
        bad_next    = bad_reg;

        if (is_digit)
        begin
            if (!count_reg[0])
            begin
                even_next = cluhn_pkg::add_mod10(even_reg, dd);
                odd_next  = cluhn_pkg::add_mod10(odd_reg, d);
            end
            else
            begin
                even_next = cluhn_pkg::add_mod10(even_reg, d);
                odd_next  = cluhn_pkg::add_mod10(odd_reg, dd);
            end
            if (count_reg == '0)
            begin
                first_next = d;
            end
            else if (count_reg == len_t'(1))
            begin
                second_next = d;
            end
        end
        else
        begin
            bad_next = 1'b1;
        end

        count_next = (count_reg < LIMIT) ? count_reg + len_t'(1) : count_reg;

        // length parity picks which doubling phase was right
        luhn = count_next[0] ? odd_next : even_next;

        class_next = cluhn_pkg::CLASS_INVALID;
        if ((first_next == 4'd3) && ((second_next == 4'd4) || (second_next == 4'd7))
            && (count_next == LEN_15))
        begin
            class_next = cluhn_pkg::CLASS_AMEX;
        end
        else if ((first_next == 4'd4) && ((count_next == LEN_13) || (count_next == LEN_16)))
        begin
            class_next = cluhn_pkg::CLASS_VISA;
        end
        else if ((first_next == 4'd5) && (second_next >= 4'd1) && (second_next <= 4'd5)
                 && (count_next == LEN_16))
        begin
            class_next = cluhn_pkg::CLASS_MASTER;
        end
        if (bad_next || (luhn != 4'd0))
        begin
            class_next = cluhn_pkg::CLASS_INVALID;
        end

        shown_next = (count_next > LEN_31) ? cluhn_pkg::COUNT_SHOW : count_next[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            even_reg   <= '0;
            odd_reg    <= '0;
            bad_reg    <= 1'b0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                count_reg  <= '0;
                first_reg  <= '0;
                second_reg <= '0;
                even_reg   <= '0;
                odd_reg    <= '0;
                bad_reg    <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                even_reg   <= even_next;
                odd_reg    <= odd_next;
                bad_reg    <= bad_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
        begin
            class_reg <= class_next;
            shown_reg <= shown_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.card_class  = class_reg;
    assign result.digit_count = shown_reg;

`ifndef SYNTH

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_reg) |=> (count_reg == '0) && !bad_reg)
        else $error("number state not cleared after last item");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && last_reg))
        else $error("result appeared without a last item");

    a_class_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (class_reg != cluhn_pkg::CLASS_INVALID)) |->
        ((shown_reg == 5'd13) || (shown_reg == 5'd15) || (shown_reg == 5'd16)))
        else $error("valid class with impossible length");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(char_reg) && $stable(last_reg))
        else $error("stalled input stage lost its item");

`endif

endmodule

`default_nettype wire

/* test/card_number_luhn_classifier_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_tb
// streams card numbers one character per item through the classifier and
// checks every class and count against a running luhn and prefix predictor or a typed table entry
// ----------------------------------------------------------------------------

module card_number_luhn_classifier_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int COUNT_LIMIT  = 31;
    localparam int TOTAL_ITEMS  = 1200;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        cluhn_pkg::class_t cls;
        cluhn_pkg::count_t cnt;
    } card_result_t;

    typedef struct packed {
        cluhn_pkg::char_t  ch;
        logic              last;
        logic              typed;
        cluhn_pkg::class_t cls;
        cluhn_pkg::count_t cnt;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]        count;
        cluhn_pkg::digit_t lead;
        cluhn_pkg::digit_t second;
        cluhn_pkg::digit_t sum_even;
        cluhn_pkg::digit_t sum_odd;
        logic              bad;
    } number_state_t;

    typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_PERIODIC, SINK_COIN} sink_mode_t;

    logic clk;
    logic rst_n;

    cluhn_char_if   chars_if ();
    cluhn_result_if result_if ();

    card_number_luhn_classifier #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if),
        .result (result_if)
    );

    number_state_t     number_state = '0;
    card_result_t      pending_classes [$];
    cluhn_pkg::char_t  number_chars [$];
    int                mismatches   = 0;
    int                items_sent   = 0;
    int                burst_left   = 0;
    int                quiet_cycles = 0;
    int                sink_cycle   = 0;
    bit                hold_req     = 1'b0;
    bit                drained_once = 1'b0;
    card_result_t      want_res;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, cluhn_pkg::CLASS_INVALID, 5'd1},
        '{8'hFF, 1'b1, 1'b1, cluhn_pkg::CLASS_INVALID, 5'd1},
        '{8'h30, 1'b1, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h39, 1'b1, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h33, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h37, 1'b1, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h35, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h2F, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h3A, 1'b1, 1'b1, cluhn_pkg::CLASS_INVALID, 5'd3},
        '{8'h34, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b0, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0},
        '{8'h32, 1'b1, 1'b0, cluhn_pkg::CLASS_INVALID, 5'd0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic cluhn_pkg::digit_t luhn_twice(input int d);
        return cluhn_pkg::digit_t'((2 * d > 9) ? 2 * d - 9 : 2 * d);
    endfunction

    function automatic cluhn_pkg::digit_t add_ten(input cluhn_pkg::digit_t a,
                                                  input cluhn_pkg::digit_t b);
        return cluhn_pkg::digit_t'((int'(a) + int'(b)) % 10);
    endfunction

    // advances the number state by one character, gives the class on the last one
    function automatic bit classify_char(input cluhn_pkg::char_t c, input bit last,
                                         output card_result_t r);
        cluhn_pkg::digit_t d;
        cluhn_pkg::digit_t luhn;
        cluhn_pkg::class_t cls;
        r = '0;
        if (c >= cluhn_pkg::CHAR_ZERO && c <= cluhn_pkg::CHAR_NINE)
        begin
            d = cluhn_pkg::digit_t'(c - cluhn_pkg::CHAR_ZERO);
            if (!number_state.count[0])
            begin
                number_state.sum_even = add_ten(number_state.sum_even, luhn_twice(d));
                number_state.sum_odd  = add_ten(number_state.sum_odd, d);
            end
            else
            begin
                number_state.sum_even = add_ten(number_state.sum_even, d);
                number_state.sum_odd  = add_ten(number_state.sum_odd, luhn_twice(d));
            end
            if (number_state.count == 0)
                number_state.lead = d;
            else if (number_state.count == 1)
                number_state.second = d;
        end
        else
        begin
            number_state.bad = 1'b1;
        end
        if (number_state.count < COUNT_LIMIT)
            number_state.count++;
        if (!last)
            return 1'b0;
        luhn = number_state.count[0] ? number_state.sum_odd : number_state.sum_even;
        cls  = cluhn_pkg::CLASS_INVALID;
        if (number_state.lead == 3 && (number_state.second == 4 || number_state.second == 7)
            && number_state.count == 15)
            cls = cluhn_pkg::CLASS_AMEX;
        else if (number_state.lead == 4 && (number_state.count == 13 || number_state.count == 16))
            cls = cluhn_pkg::CLASS_VISA;
        else if (number_state.lead == 5 && number_state.second >= 1 && number_state.second <= 5
                 && number_state.count == 16)
            cls = cluhn_pkg::CLASS_MASTER;
        if (number_state.bad || luhn != 0)
            cls = cluhn_pkg::CLASS_INVALID;
        r.cls = cls;
        r.cnt = cluhn_pkg::count_t'((number_state.count > cluhn_pkg::COUNT_SHOW)
                                    ? cluhn_pkg::COUNT_SHOW : number_state.count);
        number_state = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // offers one item at a falling edge, returns at the falling edge after acceptance
    task automatic send_char(input cluhn_pkg::char_t c, input bit last, input bit typed,
                             input cluhn_pkg::class_t t_cls, input cluhn_pkg::count_t t_cnt);
        card_result_t got;
        int           gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                chars_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 24);
        end
        chars_if.valid     <= 1'b1;
        chars_if.char_code <= c;
        chars_if.is_last   <= last;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        if (classify_char(c, last, got))
            pending_classes.push_back(typed ? card_result_t'{t_cls, t_cnt} : got);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_number();
        for (int i = 0; i < number_chars.size(); i++)
            send_char(number_chars[i], i == number_chars.size() - 1, 1'b0,
                      cluhn_pkg::CLASS_INVALID, '0);
    endtask

    // mix of digits and arbitrary bytes
    task automatic build_run(input int len, input int byte_pct);
        number_chars.delete();
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < byte_pct)
                number_chars.push_back(cluhn_pkg::char_t'($urandom_range(0, 255)));
            else
                number_chars.push_back(cluhn_pkg::char_t'(cluhn_pkg::CHAR_ZERO
                                                          + $urandom_range(0, 9)));
        end
    endtask

    // issuer-shaped number, optionally with one fault
    task automatic build_card(input bit clean);
        int dig [0:23];
        int len;
        int fault;
        int sum;
        int check;
        int pos;
        case ($urandom_range(0, 2))
            0:
            begin
                len    = 15;
                dig[0] = 3;
                dig[1] = $urandom_range(0, 1) ? 4 : 7;
            end
            1:
            begin
                len    = $urandom_range(0, 1) ? 13 : 16;
                dig[0] = 4;
                dig[1] = $urandom_range(0, 9);
            end
            default:
            begin
                len    = 16;
                dig[0] = 5;
                dig[1] = $urandom_range(1, 5);
            end
        endcase
        fault = clean ? 0 : $urandom_range(1, 4);
        if (fault == 1)
            len = $urandom_range(0, 1) ? len + $urandom_range(1, 2) : len - $urandom_range(1, 2);
        if (fault == 2)
        begin
            dig[0] = $urandom_range(0, 9);
            dig[1] = $urandom_range(0, 9);
        end
        for (int i = 2; i < len - 1; i++)
            dig[i] = $urandom_range(0, 9);
        sum = 0;
        for (int i = 0; i < len - 1; i++)
            sum += ((len - 1 - i) % 2 == 1) ? int'(luhn_twice(dig[i])) : dig[i];
        check = (10 - sum % 10) % 10;
        dig[len - 1] = (fault == 3) ? (check + $urandom_range(1, 9)) % 10 : check;
        number_chars.delete();
        for (int i = 0; i < len; i++)
            number_chars.push_back(cluhn_pkg::char_t'(cluhn_pkg::CHAR_ZERO + dig[i]));
        if (fault == 4)
        begin
            pos = $urandom_range(0, len - 1);
            number_chars[pos] = $urandom_range(0, 1)
                                ? cluhn_pkg::char_t'($urandom_range(0, 47))
                                : cluhn_pkg::char_t'($urandom_range(58, 255));
        end
    endtask

    // result side: checks every accepted item against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_classes.size() == 0)
            begin
                report_mismatch("unexpected result, class", result_if.card_class, 0);
            end
            else
            begin
                want_res = pending_classes.pop_front();
                if (result_if.card_class !== want_res.cls)
                    report_mismatch("card_class", result_if.card_class, want_res.cls);
                if (result_if.digit_count !== want_res.cnt)
                    report_mismatch("digit_count", result_if.digit_count, want_res.cnt);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("card_number_luhn_classifier verification failed");
            $finish;
        end
    end

    // receiver stall pattern and the long hold-off
    initial
    begin
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            sink_cycle++;
            case (sink_mode_t'((sink_cycle / 200) % 4))
                SINK_OPEN:     result_if.ready <= 1'b1;
                SINK_LIGHT:    result_if.ready <= ($urandom_range(0, 9) < 7);
                SINK_PERIODIC: result_if.ready <= ((sink_cycle % 7) < 2);
                default:       result_if.ready <= $urandom_range(0, 1);
            endcase
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.char_code = '0;
        chars_if.is_last   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_table[i].ch, dir_table[i].last, dir_table[i].typed,
                      dir_table[i].cls, dir_table[i].cnt);

        // short numbers while the receiver holds off, so the input backs up
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
        begin
            build_run($urandom_range(1, 2), 30);
            send_number();
        end

        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: build_card(1'b1);
                6, 7:             build_card(1'b0);
                8:                build_run($urandom_range(1, 20), 50);
                default:          build_run($urandom_range(28, 40), 0);
            endcase
            send_number();
            if (!drained_once && items_sent >= TOTAL_ITEMS / 2)
            begin
                chars_if.valid <= 1'b0;
                while (pending_classes.size() != 0)
                    @(posedge clk);
                @(negedge clk);
                drained_once = 1'b1;
            end
        end
        chars_if.valid <= 1'b0;

        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("card_number_luhn_classifier verification clean");
        else
            $display("card_number_luhn_classifier verification failed");
        $finish;
    end

endmodule
